// ===== sv/csvt_pkg.sv =====
// Package for the CSV field tokenizer: character codes, parser modes, result kinds and types.
`default_nettype none

package csvt_pkg;

  localparam logic [7:0] CH_QUOTE   = 8'd34;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_COMMA   = 8'd44;

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_END  = 1'b1;

  localparam logic [2:0] M_START    = 3'd0;
  localparam logic [2:0] M_PLAIN    = 3'd1;
  localparam logic [2:0] M_PLAIN_Q  = 3'd2;
  localparam logic [2:0] M_QUOTED   = 3'd3;
  localparam logic [2:0] M_QUOTED_Q = 3'd4;
  localparam logic [2:0] M_BLANKS   = 3'd5;
  localparam logic [2:0] M_ERROR    = 3'd6;

  localparam logic [2:0] K_BYTE   = 3'd0;
  localparam logic [2:0] K_FIELD  = 3'd1;
  localparam logic [2:0] K_RECORD = 3'd2;
  localparam logic [2:0] K_EMPTY  = 3'd3;
  localparam logic [2:0] K_ERROR  = 3'd4;

  localparam logic E_QUOTE = 1'b0;
  localparam logic E_TRAIL = 1'b1;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] byte_val;
    logic       err;
  } result_t;

  typedef struct packed {
    logic       push;
    result_t    res;
    logic [2:0] mode_nxt;
    logic       line_nxt;
  } step_t;

endpackage

`default_nettype wire

// ===== sv/csvt_step.sv =====
// Next-state and result decode for one input request of the CSV tokenizer.
`default_nettype none

module csvt_step (
  input  wire logic         action,
  input  wire logic [7:0]   data_byte,
  input  wire logic [7:0]   delimiter,
  input  wire logic [2:0]   mode,
  input  wire logic         line_start,
  output csvt_pkg::step_t   step
);
  import csvt_pkg::*;

  logic is_nl, is_q, is_delim, is_blank;

  assign is_nl    = (data_byte == CH_NEWLINE);
  assign is_q     = (data_byte == CH_QUOTE);
  assign is_delim = (data_byte == delimiter);
  assign is_blank = (data_byte == CH_SPACE) || (data_byte == CH_TAB);

  always_comb begin
    step          = '0;
    step.mode_nxt = mode;
    step.line_nxt = line_start;
    if (mode >= M_ERROR) begin
      // Silent until reset; the unused mode value behaves the same way.
    end else if (action == ACT_END) begin
      if (mode == M_PLAIN_Q) begin
        step.push     = 1'b1;
        step.res.kind = K_ERROR;
        step.res.err  = E_QUOTE;
        step.mode_nxt = M_ERROR;
      end else if (!(mode == M_START && line_start)) begin
        step.push     = 1'b1;
        step.res.kind = K_RECORD;
        step.mode_nxt = M_START;
        step.line_nxt = 1'b1;
      end
    end else begin
      unique case (mode)
        M_START: begin
          if (is_nl) begin
            step.push     = 1'b1;
            step.res.kind = line_start ? K_EMPTY : K_RECORD;
            step.line_nxt = 1'b1;
          end else begin
            step.line_nxt = 1'b0;
            if (is_q) begin
              step.mode_nxt = M_QUOTED;
            end else if (is_delim) begin
              step.push     = 1'b1;
              step.res.kind = K_FIELD;
            end else begin
              step.push         = 1'b1;
              step.res.kind     = K_BYTE;
              step.res.byte_val = data_byte;
              step.mode_nxt     = M_PLAIN;
            end
          end
        end
        M_PLAIN: begin
          if (is_nl) begin
            step.push     = 1'b1;
            step.res.kind = K_RECORD;
            step.mode_nxt = M_START;
            step.line_nxt = 1'b1;
          end else if (is_q) begin
            step.mode_nxt = M_PLAIN_Q;
          end else if (is_delim) begin
            step.push     = 1'b1;
            step.res.kind = K_FIELD;
            step.mode_nxt = M_START;
          end else begin
            step.push         = 1'b1;
            step.res.kind     = K_BYTE;
            step.res.byte_val = data_byte;
          end
        end
        M_PLAIN_Q: begin
          step.push = 1'b1;
          if (is_q) begin
            step.res.kind     = K_BYTE;
            step.res.byte_val = CH_QUOTE;
            step.mode_nxt     = M_PLAIN;
          end else begin
            step.res.kind = K_ERROR;
            step.res.err  = E_QUOTE;
            step.mode_nxt = M_ERROR;
          end
        end
        M_QUOTED: begin
          if (is_q) begin
            step.mode_nxt = M_QUOTED_Q;
          end else begin
            step.push         = 1'b1;
            step.res.kind     = K_BYTE;
            step.res.byte_val = data_byte;
          end
        end
        M_QUOTED_Q, M_BLANKS: begin
          if (mode == M_QUOTED_Q && is_q) begin
            step.push         = 1'b1;
            step.res.kind     = K_BYTE;
            step.res.byte_val = CH_QUOTE;
            step.mode_nxt     = M_QUOTED;
          end else if (is_nl) begin
            step.push     = 1'b1;
            step.res.kind = K_RECORD;
            step.mode_nxt = M_START;
            step.line_nxt = 1'b1;
          end else if (is_delim) begin
            step.push     = 1'b1;
            step.res.kind = K_FIELD;
            step.mode_nxt = M_START;
          end else if (is_blank) begin
            step.mode_nxt = M_BLANKS;
          end else begin
            step.push     = 1'b1;
            step.res.kind = K_ERROR;
            step.res.err  = E_TRAIL;
            step.mode_nxt = M_ERROR;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/csvt_out_buf.sv =====
// Two-entry result buffer that separates the parser from the result channel's stall.
`default_nettype none

module csvt_out_buf (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire csvt_pkg::result_t push_res,
  output logic                   full,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output csvt_pkg::result_t      out_res
);
  import csvt_pkg::*;

  result_t    slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       pop;

  assign full      = (count_r == 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign out_res   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_res;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3) else $error("result buffer count out of range");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("push into a full result buffer");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 2'd1)
    else $error("result buffer count did not advance on push");

endmodule

`default_nettype wire

// ===== sv/csv_field_tokenizer.sv =====
// Top level of the streaming CSV field tokenizer: mode, delimiter and result buffer.
//
//  Channel  Direction  Handshake            Payload
//  in_      request    in_valid / in_stall  in_action, in_data_byte
//  out_     result     out_valid/out_stall  out_kind, out_byte, out_error_code
//  cfg_     write      cfg_valid/cfg_ready  cfg_data (delimiter)
//
// One input request is taken every cycle while in_stall is low; its result,
// if it has one, is registered in the result buffer and offered from its head.
// The parser mode register is updated in the same cycle that a request is accepted.
// A two-entry result buffer lets requests keep flowing while one result waits;
// in_stall rises only when both entries are occupied.
// Reset (rst_n low, synchronous) restores the comma delimiter, field start and
// line start, and empties the result buffer.
`default_nettype none

module csv_field_tokenizer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_action,
  input  wire logic [7:0] in_data_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      out_kind,
  output logic [7:0]      out_byte,
  output logic            out_error_code,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data
);
  import csvt_pkg::*;

  // Parser state: current mode and whether any byte of this line has been taken.
  logic [2:0] mode_r, mode_nxt;
  logic       line_r, line_nxt;
  logic [7:0] delim_r, delim_nxt;
  logic       in_accept;
  logic       buf_full;
  step_t      step;
  result_t    res;

  // The configuration port never holds off a write.
  assign cfg_ready = 1'b1;

  assign in_stall  = buf_full;
  assign in_accept = in_valid && !in_stall;

  // Work out the effect of the offered request against the present state.
  csvt_step u_step (
    .action     (in_action),
    .data_byte  (in_data_byte),
    .delimiter  (delim_r),
    .mode       (mode_r),
    .line_start (line_r),
    .step       (step)
  );

  // Mode and line state only move when the request is actually taken.
  always_comb begin
    mode_nxt  = in_accept ? step.mode_nxt : mode_r;
    line_nxt  = in_accept ? step.line_nxt : line_r;
    delim_nxt = (cfg_valid && cfg_ready) ? cfg_data : delim_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_START;
      line_r  <= 1'b1;
      delim_r <= CH_COMMA;
    end else begin
      mode_r  <= mode_nxt;
      line_r  <= line_nxt;
      delim_r <= delim_nxt;
    end
  end

  // Results are registered in the buffer; the output ports read its head entry.
  csvt_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept && step.push),
    .push_res  (step.res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_kind       = res.kind;
  assign out_byte       = res.byte_val;
  assign out_error_code = res.err;

  // Once in the error mode the parser must stay silent.
  a_error_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r >= M_ERROR) |-> !step.push)
    else $error("result produced while in the error mode");

  // An error result always parks the parser in the error mode.
  a_error_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && step.push && step.res.kind == K_ERROR) |=> mode_r == M_ERROR)
    else $error("error result without entering the error mode");

  // An empty record can only come from a newline at the start of a line.
  a_empty_line: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && step.push && step.res.kind == K_EMPTY)
      |-> (mode_r == M_START && line_r && in_action == ACT_BYTE))
    else $error("empty record outside line start");

endmodule

`default_nettype wire
